>>> src/xxh64_stream_hash_assert.svh
// Assertion macros for the checker file of the hash block.
`ifndef XXH64_STREAM_HASH_ASSERT_SVH
`define XXH64_STREAM_HASH_ASSERT_SVH

// Same-cycle implication, clocked on clk and held off during reset.
`define XXH_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("xxh64 check failed");

// Next-cycle implication, clocked on clk and held off during reset.
`define XXH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("xxh64 check failed");

`endif

>>> src/xxh_pkg.sv
// Shared constants, codes and command types of the XXH64 stream hash.
`default_nettype none
package xxh_pkg;

	localparam logic [63:0] PR1 = 64'h9E3779B185EBCA87;
	localparam logic [63:0] PR2 = 64'hC2B2AE3D27D4EB4F;
	localparam logic [63:0] PR3 = 64'h165667B19E3779F9;
	localparam logic [63:0] PR4 = 64'h85EBCA77C2B2AE63;
	localparam logic [63:0] PR5 = 64'h27D4EB2F165667C5;

	// Multiplier operand source
	typedef enum logic [3:0] {
		A_WORD   = 4'd0,
		A_T      = 4'd1,
		A_LANE   = 4'd2,
		A_H      = 4'd3,
		A_HROT27 = 4'd4,
		A_HROT23 = 4'd5,
		A_HROT11 = 4'd6,
		A_HSH33  = 4'd7,
		A_W32    = 4'd8,
		A_BYTE   = 4'd9
	} a_src_t;

	// Multiplier constant
	typedef enum logic [1:0] {
		K_P1 = 2'd0,
		K_P2 = 2'd1,
		K_P3 = 2'd2,
		K_P5 = 2'd3
	} k_sel_t;

	// What to do with the finished product
	typedef enum logic [3:0] {
		P_LANE_ADD = 4'd0,
		P_T_ROT31  = 4'd1,
		P_LANE_SET = 4'd2,
		P_H_XOR    = 4'd3,
		P_H_PR4    = 4'd4,
		P_H_PR3    = 4'd5,
		P_H_SET    = 4'd6,
		P_H_AVAL   = 4'd7,
		P_H_FINAL  = 4'd8
	} post_t;

	// Datapath operations outside the multiplier
	typedef enum logic [2:0] {
		OP_NONE    = 3'd0,
		OP_CAPTURE = 3'd1,
		OP_CONV    = 3'd2,
		OP_SHORT   = 3'd3,
		OP_ADDLEN  = 3'd4,
		OP_FINISH  = 3'd5
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       mul_run;
		logic [1:0] mul_ph;
		a_src_t     a_src;
		k_sel_t     k_sel;
		post_t      post;
		logic [1:0] idx;
		logic [2:0] bidx;
		logic [3:0] add_len;
		logic       buf_wr;
	} dp_cmd_t;

	typedef struct packed {
		logic len_ge32;
	} dp_stat_t;

endpackage
`default_nettype wire

>>> src/xxh_dp.sv
// Datapath: lanes, stripe buffer, length, hash register and shared multiplier.
`default_nettype none
module xxh_dp (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire xxh_pkg::dp_cmd_t cmd,
	input  wire logic             seed_we,
	input  wire logic [63:0]      seed_data,
	input  wire logic [63:0]      data_word,
	output xxh_pkg::dp_stat_t     stat,
	output logic [63:0]           hash_value
);

	function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
		return (x << r) | (x >> (64 - r));
	endfunction

	function automatic logic [63:0] lane_init(input logic [63:0] s, input logic [1:0] i);
		logic [63:0] v;
		unique case (i)
			2'd0: v = s + xxh_pkg::PR1 + xxh_pkg::PR2;
			2'd1: v = s + xxh_pkg::PR2;
			2'd2: v = s;
			default: v = s - xxh_pkg::PR1;
		endcase
		return v;
	endfunction

	logic [63:0] seed_q;
	logic [63:0] lane_q [4];
	logic [63:0] len_q;
	logic [63:0] buf_q [3];
	logic [63:0] w_q, t_q, h_q, a_q, k_q, p_q, hash_q;

	logic [63:0] word_sel, a_sel, k_val, prod;
	logic [31:0] m_x, m_y;
	logic [7:0]  byte_v;
	logic        post_en;

	assign post_en = cmd.mul_run && (cmd.mul_ph == 2'd3);
	assign byte_v  = w_q[{cmd.bidx, 3'b000} +: 8];

	always_comb begin
		unique case (cmd.idx)
			2'd0: word_sel = buf_q[0];
			2'd1: word_sel = buf_q[1];
			2'd2: word_sel = buf_q[2];
			default: word_sel = w_q;
		endcase
	end

	always_comb begin
		unique case (cmd.a_src)
			xxh_pkg::A_WORD:   a_sel = word_sel;
			xxh_pkg::A_T:      a_sel = t_q;
			xxh_pkg::A_LANE:   a_sel = lane_q[cmd.idx];
			xxh_pkg::A_H:      a_sel = h_q;
			xxh_pkg::A_HROT27: a_sel = rotl(h_q, 27);
			xxh_pkg::A_HROT23: a_sel = rotl(h_q, 23);
			xxh_pkg::A_HROT11: a_sel = rotl(h_q, 11);
			xxh_pkg::A_HSH33:  a_sel = h_q ^ (h_q >> 33);
			xxh_pkg::A_W32:    a_sel = {32'd0, w_q[31:0]};
			xxh_pkg::A_BYTE:   a_sel = {56'd0, byte_v};
			default:           a_sel = h_q;
		endcase
	end

	always_comb begin
		unique case (cmd.k_sel)
			xxh_pkg::K_P1: k_val = xxh_pkg::PR1;
			xxh_pkg::K_P2: k_val = xxh_pkg::PR2;
			xxh_pkg::K_P3: k_val = xxh_pkg::PR3;
			default:       k_val = xxh_pkg::PR5;
		endcase
	end

	// One 32x32 product per cycle: lo*lo, then the two cross terms.
	always_comb begin
		unique case (cmd.mul_ph)
			2'd0: begin
				m_x = a_sel[31:0];
				m_y = k_val[31:0];
			end
			2'd1: begin
				m_x = a_q[31:0];
				m_y = k_q[63:32];
			end
			default: begin
				m_x = a_q[63:32];
				m_y = k_q[31:0];
			end
		endcase
	end

	assign prod = 64'(m_x) * 64'(m_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			len_q  <= '0;
			for (int i = 0; i < 4; i++) lane_q[i] <= lane_init(64'd0, 2'(i));
		end else if (seed_we) begin
			seed_q <= seed_data;
			len_q  <= '0;
			for (int i = 0; i < 4; i++) lane_q[i] <= lane_init(seed_data, 2'(i));
		end else begin
			if (cmd.op == xxh_pkg::OP_CAPTURE) len_q <= len_q + 64'(cmd.add_len);
			if (cmd.op == xxh_pkg::OP_FINISH) begin
				len_q <= '0;
				for (int i = 0; i < 4; i++) lane_q[i] <= lane_init(seed_q, 2'(i));
			end
			if (post_en && cmd.post == xxh_pkg::P_LANE_SET) lane_q[cmd.idx] <= p_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == xxh_pkg::OP_CAPTURE) begin
			w_q <= data_word;
			if (cmd.buf_wr) begin
				unique case (cmd.idx)
					2'd0: buf_q[0] <= data_word;
					2'd1: buf_q[1] <= data_word;
					default: buf_q[2] <= data_word;
				endcase
			end
		end
		if (cmd.mul_run) begin
			unique case (cmd.mul_ph)
				2'd0: begin
					a_q <= a_sel;
					k_q <= k_val;
					p_q <= prod;
				end
				2'd1, 2'd2: p_q <= p_q + {prod[31:0], 32'd0};
				default: ;
			endcase
		end
		if (post_en) begin
			unique case (cmd.post)
				xxh_pkg::P_LANE_ADD: t_q <= rotl(lane_q[cmd.idx] + p_q, 31);
				xxh_pkg::P_T_ROT31:  t_q <= rotl(p_q, 31);
				xxh_pkg::P_H_XOR:    h_q <= h_q ^ p_q;
				xxh_pkg::P_H_PR4:    h_q <= p_q + xxh_pkg::PR4;
				xxh_pkg::P_H_PR3:    h_q <= p_q + xxh_pkg::PR3;
				xxh_pkg::P_H_SET:    h_q <= p_q;
				xxh_pkg::P_H_AVAL:   h_q <= p_q ^ (p_q >> 29);
				xxh_pkg::P_H_FINAL:  h_q <= p_q ^ (p_q >> 32);
				default: ;
			endcase
		end
		unique case (cmd.op)
			xxh_pkg::OP_CONV: h_q <= rotl(lane_q[0], 1) + rotl(lane_q[1], 7) +
				rotl(lane_q[2], 12) + rotl(lane_q[3], 18);
			xxh_pkg::OP_SHORT:  h_q <= seed_q + xxh_pkg::PR5 + len_q;
			xxh_pkg::OP_ADDLEN: h_q <= h_q + len_q;
			xxh_pkg::OP_FINISH: hash_q <= h_q;
			default: ;
		endcase
	end

	assign stat.len_ge32 = |len_q[63:5];
	assign hash_value    = hash_q;

endmodule
`default_nettype wire

>>> src/xxh_ctrl.sv
// Controller: handshakes, stripe fill, tail sequencing and multiplier phases.
`default_nettype none
module xxh_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              last,
	input  wire logic [3:0]        last_bytes,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire logic              seed_we,
	input  wire xxh_pkg::dp_stat_t stat,
	output xxh_pkg::dp_cmd_t       cmd
);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_STRIPE = 10'b0000000010,
		S_FIN    = 10'b0000000100,
		S_MERGE  = 10'b0000001000,
		S_ADDLEN = 10'b0000010000,
		S_TAIL8  = 10'b0000100000,
		S_TAIL4  = 10'b0001000000,
		S_BYTE   = 10'b0010000000,
		S_AVAL   = 10'b0100000000,
		S_OUT    = 10'b1000000000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] mph_q, mph_d, sub_q, sub_d, idx_q, idx_d, fill_q, fill_d;
	logic [2:0] bidx_q, bidx_d;
	logic [3:0] nb_q, nb_d, n_clamp;
	logic       last_q, last_d, ov_q, ov_d, instr_done;
	state_t     after8_st, tail_st;
	logic [1:0] tail_idx;

	assign n_clamp    = last_bytes[3] ? 4'd8 : last_bytes;
	assign instr_done = (mph_q == 2'd3);

	always_comb begin
		if (nb_q == 4'd8)       after8_st = S_AVAL;
		else if (nb_q >= 4'd4)  after8_st = S_TAIL4;
		else if (nb_q != 4'd0)  after8_st = S_BYTE;
		else                    after8_st = S_AVAL;
		if (fill_q != 2'd0) begin
			tail_st  = S_TAIL8;
			tail_idx = 2'd0;
		end else if (nb_q == 4'd8) begin
			tail_st  = S_TAIL8;
			tail_idx = 2'd3;
		end else begin
			tail_st  = after8_st;
			tail_idx = 2'd0;
		end
	end

	always_comb begin
		state_d = state_q;
		mph_d   = mph_q;
		sub_d   = sub_q;
		idx_d   = idx_q;
		bidx_d  = bidx_q;
		fill_d  = fill_q;
		nb_d    = nb_q;
		last_d  = last_q;
		ov_d    = ov_q && out_stall;

		cmd         = '0;
		cmd.mul_ph  = mph_q;
		cmd.idx     = idx_q;
		cmd.bidx    = bidx_q;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = xxh_pkg::OP_CAPTURE;
					if (!last) begin
						cmd.add_len = 4'd8;
						last_d      = 1'b0;
						if (fill_q != 2'd3) begin
							cmd.buf_wr = 1'b1;
							cmd.idx    = fill_q;
							fill_d     = fill_q + 2'd1;
						end else begin
							state_d = S_STRIPE;
							idx_d   = 2'd0;
						end
					end else begin
						cmd.add_len = n_clamp;
						last_d      = 1'b1;
						if (n_clamp == 4'd8 && fill_q == 2'd3) begin
							// full word closes a stripe; tail is then empty
							nb_d    = 4'd0;
							state_d = S_STRIPE;
							idx_d   = 2'd0;
						end else begin
							nb_d    = n_clamp;
							state_d = S_FIN;
						end
					end
				end
			end
			S_STRIPE: begin
				cmd.mul_run = 1'b1;
				if (sub_q == 2'd0) begin
					cmd.a_src = xxh_pkg::A_WORD;
					cmd.k_sel = xxh_pkg::K_P2;
					cmd.post  = xxh_pkg::P_LANE_ADD;
				end else begin
					cmd.a_src = xxh_pkg::A_T;
					cmd.k_sel = xxh_pkg::K_P1;
					cmd.post  = xxh_pkg::P_LANE_SET;
				end
				mph_d = mph_q + 2'd1;
				if (instr_done) begin
					if (sub_q == 2'd0) begin
						sub_d = 2'd1;
					end else begin
						sub_d = 2'd0;
						if (idx_q == 2'd3) begin
							fill_d  = 2'd0;
							state_d = last_q ? S_FIN : S_IDLE;
						end else begin
							idx_d = idx_q + 2'd1;
						end
					end
				end
			end
			S_FIN: begin
				if (stat.len_ge32) begin
					cmd.op  = xxh_pkg::OP_CONV;
					state_d = S_MERGE;
					idx_d   = 2'd0;
				end else begin
					cmd.op  = xxh_pkg::OP_SHORT;
					state_d = tail_st;
					idx_d   = tail_idx;
					bidx_d  = 3'd0;
				end
			end
			S_MERGE, S_TAIL8: begin
				cmd.mul_run = 1'b1;
				unique case (sub_q)
					2'd0: begin
						cmd.a_src = (state_q == S_MERGE) ? xxh_pkg::A_LANE : xxh_pkg::A_WORD;
						cmd.k_sel = xxh_pkg::K_P2;
						cmd.post  = xxh_pkg::P_T_ROT31;
					end
					2'd1: begin
						cmd.a_src = xxh_pkg::A_T;
						cmd.k_sel = xxh_pkg::K_P1;
						cmd.post  = xxh_pkg::P_H_XOR;
					end
					default: begin
						cmd.a_src = (state_q == S_MERGE) ? xxh_pkg::A_H : xxh_pkg::A_HROT27;
						cmd.k_sel = xxh_pkg::K_P1;
						cmd.post  = xxh_pkg::P_H_PR4;
					end
				endcase
				mph_d = mph_q + 2'd1;
				if (instr_done) begin
					if (sub_q != 2'd2) begin
						sub_d = sub_q + 2'd1;
					end else begin
						sub_d = 2'd0;
						if (state_q == S_MERGE) begin
							if (idx_q == 2'd3) state_d = S_ADDLEN;
							else               idx_d   = idx_q + 2'd1;
						end else begin
							priority if (idx_q != 2'd3 && (3'(idx_q) + 3'd1) < 3'(fill_q)) begin
								idx_d = idx_q + 2'd1;
							end else if (idx_q != 2'd3 && nb_q == 4'd8) begin
								idx_d = 2'd3;
							end else begin
								state_d = after8_st;
								bidx_d  = 3'd0;
							end
						end
					end
				end
			end
			S_ADDLEN: begin
				cmd.op  = xxh_pkg::OP_ADDLEN;
				state_d = tail_st;
				idx_d   = tail_idx;
				bidx_d  = 3'd0;
			end
			S_TAIL4: begin
				cmd.mul_run = 1'b1;
				if (sub_q == 2'd0) begin
					cmd.a_src = xxh_pkg::A_W32;
					cmd.k_sel = xxh_pkg::K_P1;
					cmd.post  = xxh_pkg::P_H_XOR;
				end else begin
					cmd.a_src = xxh_pkg::A_HROT23;
					cmd.k_sel = xxh_pkg::K_P2;
					cmd.post  = xxh_pkg::P_H_PR3;
				end
				mph_d = mph_q + 2'd1;
				if (instr_done) begin
					if (sub_q == 2'd0) begin
						sub_d = 2'd1;
					end else begin
						sub_d = 2'd0;
						if (nb_q > 4'd4) begin
							state_d = S_BYTE;
							bidx_d  = 3'd4;
						end else begin
							state_d = S_AVAL;
						end
					end
				end
			end
			S_BYTE: begin
				cmd.mul_run = 1'b1;
				if (sub_q == 2'd0) begin
					cmd.a_src = xxh_pkg::A_BYTE;
					cmd.k_sel = xxh_pkg::K_P5;
					cmd.post  = xxh_pkg::P_H_XOR;
				end else begin
					cmd.a_src = xxh_pkg::A_HROT11;
					cmd.k_sel = xxh_pkg::K_P1;
					cmd.post  = xxh_pkg::P_H_SET;
				end
				mph_d = mph_q + 2'd1;
				if (instr_done) begin
					if (sub_q == 2'd0) begin
						sub_d = 2'd1;
					end else begin
						sub_d = 2'd0;
						if ((4'(bidx_q) + 4'd1) < nb_q) bidx_d  = bidx_q + 3'd1;
						else                            state_d = S_AVAL;
					end
				end
			end
			S_AVAL: begin
				cmd.mul_run = 1'b1;
				if (sub_q == 2'd0) begin
					cmd.a_src = xxh_pkg::A_HSH33;
					cmd.k_sel = xxh_pkg::K_P2;
					cmd.post  = xxh_pkg::P_H_AVAL;
				end else begin
					cmd.a_src = xxh_pkg::A_H;
					cmd.k_sel = xxh_pkg::K_P3;
					cmd.post  = xxh_pkg::P_H_FINAL;
				end
				mph_d = mph_q + 2'd1;
				if (instr_done) begin
					if (sub_q == 2'd0) begin
						sub_d = 2'd1;
					end else begin
						sub_d   = 2'd0;
						state_d = S_OUT;
					end
				end
			end
			S_OUT: begin
				// hold until the output register is free
				if (!ov_q || !out_stall) begin
					cmd.op  = xxh_pkg::OP_FINISH;
					ov_d    = 1'b1;
					fill_d  = 2'd0;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		if (seed_we) fill_d = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mph_q   <= '0;
			sub_q   <= '0;
			idx_q   <= '0;
			bidx_q  <= '0;
			fill_q  <= '0;
			nb_q    <= '0;
			last_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			mph_q   <= mph_d;
			sub_q   <= sub_d;
			idx_q   <= idx_d;
			bidx_q  <= bidx_d;
			fill_q  <= fill_d;
			nb_q    <= nb_d;
			last_q  <= last_d;
			ov_q    <= ov_d;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = ov_q;

endmodule
`default_nettype wire

>>> src/xxh64_stream_hash.sv
// Top level of the streaming XXH64 hash: controller plus datapath.
//
//   channel  direction  handshake             payload
//   in       to block   in_valid / in_stall   data_word, last, last_bytes
//   out      from block out_valid / out_stall hash_value
//   config   to block   hash_seed_we          hash_seed
//
// A word that only fills the stripe buffer is simply stored. A word that closes a
// 32-byte stripe runs four lane rounds of two products each, and every 64-bit
// product is built in phases on the one shared 32x32 multiplier.
// The last word adds the start value, the merge (a round per lane plus the
// length add, for messages of 32 bytes or more), a fold per buffered or full
// tail word, a step for a 4-byte tail, one per single byte, the avalanche
// and the load of the output register.
// Reset restarts from seed 0; a seed write drops the message in progress.
// The finished hash sits in an output register; a stalled result blocks only
// the transfer of the next digest, not the intake of the words before it.
`default_nettype none
module xxh64_stream_hash (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        hash_seed_we,
	input  wire logic [63:0] hash_seed,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] data_word,
	input  wire logic        last,
	input  wire logic [3:0]  last_bytes,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      hash_value
);

	xxh_pkg::dp_cmd_t  cmd;
	xxh_pkg::dp_stat_t stat;

	// sequence every transfer and multiplier phase
	xxh_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.last       (last),
		.last_bytes (last_bytes),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.seed_we    (hash_seed_we),
		.stat       (stat),
		.cmd        (cmd)
	);

	// hold lanes, buffer, length and running hash
	xxh_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.seed_we    (hash_seed_we),
		.seed_data  (hash_seed),
		.data_word  (data_word),
		.stat       (stat),
		.hash_value (hash_value)
	);

endmodule
`default_nettype wire

>>> src/xxh_checker.sv
// Port-level checks of the stream hash, bound to the top level.
`default_nettype none
`include "xxh64_stream_hash_assert.svh"
module xxh_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        last,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [63:0] hash_value
);

	`XXH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(hash_value))
	`XXH_ASSERT_NEXT(a_last_busy, in_valid && !in_stall && last, in_stall)
	`XXH_ASSERT_NEXT(a_mid_no_out, in_valid && !in_stall && !last, !$rose(out_valid))
	`XXH_ASSERT_NOW(a_out_after_work, $rose(out_valid), $past(in_stall))

endmodule

bind xxh64_stream_hash xxh_checker u_xxh_checker (.*);
`default_nettype wire

>>> verif/tb_xxh64_stream_hash.sv
// Testbench for the streaming XXH64 hash block: directed and random messages against a predictor.
`default_nettype none
module tb_xxh64_stream_hash;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        hash_seed_we = 1'b0;
	logic [63:0] hash_seed = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [63:0] data_word = '0;
	logic        last = 1'b0;
	logic [3:0]  last_bytes = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] hash_value;

	xxh64_stream_hash uut (
		.clk(clk), .arst_n(arst_n), .hash_seed_we(hash_seed_we), .hash_seed(hash_seed),
		.in_valid(in_valid), .in_stall(in_stall), .data_word(data_word), .last(last),
		.last_bytes(last_bytes), .out_valid(out_valid), .out_stall(out_stall),
		.hash_value(hash_value)
	);

	always #4 clk = ~clk;

	// Predictor state: mirrors the block's lanes, stripe buffer, fill and length.
	logic [63:0] seed_q;
	logic [63:0] lanes [4];
	logic [63:0] held_words [3];
	int unsigned held_cnt;
	logic [63:0] msg_len;
	logic [63:0] digest_q [$];
	int          err_cnt = 0;
	bit          hold_recv = 1'b0;
	bit          long_hold_req = 1'b0;

	function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
		return (x << r) | (x >> (64 - r));
	endfunction

	function automatic logic [63:0] mix_round(input logic [63:0] acc, input logic [63:0] w);
		acc = acc + w * xxh_pkg::PR2;
		return rotl(acc, 31) * xxh_pkg::PR1;
	endfunction

	function automatic logic [63:0] fold_word(input logic [63:0] h, input logic [63:0] w);
		h = h ^ mix_round(64'd0, w);
		return rotl(h, 27) * xxh_pkg::PR1 + xxh_pkg::PR4;
	endfunction

	task automatic restart_msg();
		lanes[0] = seed_q + xxh_pkg::PR1 + xxh_pkg::PR2;
		lanes[1] = seed_q + xxh_pkg::PR2;
		lanes[2] = seed_q;
		lanes[3] = seed_q - xxh_pkg::PR1;
		held_cnt = 0;
		msg_len = '0;
	endtask

	task automatic absorb_stripe(input logic [63:0] w);
		lanes[0] = mix_round(lanes[0], held_words[0]);
		lanes[1] = mix_round(lanes[1], held_words[1]);
		lanes[2] = mix_round(lanes[2], held_words[2]);
		lanes[3] = mix_round(lanes[3], w);
		held_cnt = 0;
	endtask

	// Advance the predictor by one word; push a digest when the word closes a message.
	task automatic predict_word(input logic [63:0] w, input logic lst, input logic [3:0] nb);
		logic [63:0] h;
		int unsigned n;
		int unsigned i;
		if (!lst) begin
			msg_len += 64'd8;
			if (held_cnt >= 3) absorb_stripe(w);
			else begin
				held_words[held_cnt] = w;
				held_cnt++;
			end
			return;
		end
		n = (nb > 8) ? 8 : nb;
		msg_len += n;
		if (n == 8 && held_cnt >= 3) begin
			absorb_stripe(w);
			n = 0;
		end
		if (msg_len >= 64'd32) begin
			h = rotl(lanes[0], 1) + rotl(lanes[1], 7) + rotl(lanes[2], 12) + rotl(lanes[3], 18);
			for (i = 0; i < 4; i++)
				h = (h ^ mix_round(64'd0, lanes[i])) * xxh_pkg::PR1 + xxh_pkg::PR4;
		end else h = seed_q + xxh_pkg::PR5;
		h += msg_len;
		for (i = 0; i < held_cnt; i++) h = fold_word(h, held_words[i]);
		i = 0;
		if (n == 8) begin
			h = fold_word(h, w);
			i = 8;
		end else if (n >= 4) begin
			h = h ^ ({32'd0, w[31:0]} * xxh_pkg::PR1);
			h = rotl(h, 23) * xxh_pkg::PR2 + xxh_pkg::PR3;
			i = 4;
		end
		for (; i < n; i++) begin
			h = h ^ ({56'd0, w[8*i +: 8]} * xxh_pkg::PR5);
			h = rotl(h, 11) * xxh_pkg::PR1;
		end
		h ^= h >> 33;
		h *= xxh_pkg::PR2;
		h ^= h >> 29;
		h *= xxh_pkg::PR3;
		h ^= h >> 32;
		digest_q.push_back(h);
		restart_msg();
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one word, hold it until the transfer, then predict.
	// Valid stays up after the transfer; the next word, a gap or drain() replaces it.
	task automatic send_word(input logic [63:0] w, input logic lst, input logic [3:0] nb,
			input bit idle);
		int g;
		g = idle ? gap_len() : 0;
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_word <= w;
		last <= lst;
		last_bytes <= nb;
		do @(posedge clk); while (in_stall);
		predict_word(w, lst, nb);
	endtask

	task automatic send_msg(input int words, input logic [3:0] nb, input bit idle);
		for (int k = 0; k < words; k++)
			send_word({$urandom, $urandom}, k == words - 1, (k == words - 1) ? nb : 4'($urandom),
				idle);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (digest_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_seed(input logic [63:0] s);
		drain();
		hash_seed_we <= 1'b1;
		hash_seed <= s;
		@(posedge clk);
		hash_seed_we <= 1'b0;
		seed_q = s;
		restart_msg();
	endtask

	// Receiver: random stalls, plus a long hold-off when requested.
	always @(posedge clk) begin
		if (hold_recv) out_stall <= 1'b1;
		else out_stall <= ($urandom_range(0, 99) < 25) && ($urandom_range(0, 9) != 0);
	end

	// Check each digest transfer against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (digest_q.size() == 0) begin
				$error("hash_value: unexpected result %h", hash_value);
				err_cnt++;
			end else begin
				logic [63:0] exp_h;
				exp_h = digest_q.pop_front();
				if (hash_value !== exp_h) begin
					$error("hash_value: expected %h actual %h", exp_h, hash_value);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (long_hold_req) begin
			hold_recv <= 1'b1;
			repeat (400) @(posedge clk);
			hold_recv <= 1'b0;
			long_hold_req <= 1'b0;
		end
	end

	// Cover the empty message, every tail length, oversized counts and stripe edges.
	task automatic test_directed();
		send_word(64'd0, 1'b1, 4'd0, 1'b0);
		for (int b = 1; b <= 15; b++) send_word('1, 1'b1, 4'(b), 1'b0);
		send_msg(4, 4'd8, 1'b0);
		send_msg(4, 4'd3, 1'b0);
		send_msg(3, 4'd8, 1'b0);
		send_msg(8, 4'd8, 1'b0);
		send_msg(5, 4'd0, 1'b0);
		drain();
	endtask

	// Abandon a partial message with a seed write, then walk seed extremes.
	task automatic test_seeds();
		send_word({$urandom, $urandom}, 1'b0, 4'd0, 1'b0);
		send_word({$urandom, $urandom}, 1'b0, 4'd0, 1'b0);
		write_seed(64'hFFFF_FFFF_FFFF_FFFF);
		send_msg(6, 4'd5, 1'b1);
		send_msg(1, 4'd7, 1'b1);
		write_seed(64'h5555_AAAA_0F0F_F0F0);
		send_msg(2, 4'd8, 1'b1);
		write_seed({$urandom, $urandom});
		send_msg(9, 4'd2, 1'b1);
		write_seed(64'd0);
	endtask

	// Stall the receiver for a long stretch while words keep coming.
	task automatic test_backpressure();
		long_hold_req <= 1'b1;
		for (int m = 0; m < 6; m++) send_msg(1, 4'($urandom_range(0, 8)), 1'b0);
		send_msg(5, 4'd8, 1'b0);
		drain();
	endtask

	// Random messages, mostly short, a few long, with random seeds between messages.
	task automatic test_random();
		int sent;
		int words;
		sent = 0;
		while (sent < 1480) begin
			if ($urandom_range(0, 39) == 0) write_seed({$urandom, $urandom});
			words = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
			send_msg(words, 4'($urandom_range(0, 15)), 1'b1);
			sent += words;
		end
		drain();
	endtask

	initial begin
		seed_q = '0;
		restart_msg();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_seeds();
		test_backpressure();
		test_random();
		if (err_cnt == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
